// ===== rtl/core/qnl_pkg.sv =====
// Package for the quaternion nlerp block: lane count and the fixed widths of
// the normalization, square root and divide path. No dependencies.
`default_nettype none
package qnl_pkg;

   // Quaternion components handled side by side.
   localparam int LANES = 4;
   // Largest normalized magnitude lies in [2^(UNORM_BITS-1), 2^UNORM_BITS).
   localparam int UNORM_BITS = 30;
   // Sum of four squares of normalized magnitudes.
   localparam int SQ_WIDTH = 2 * UNORM_BITS + 2;
   // Integer square root of that sum.
   localparam int ROOT_WIDTH = UNORM_BITS + 1;

endpackage
`default_nettype wire

// ===== rtl/core/quaternion_nlerp.sv =====
// Throughput is one transaction per cycle whenever the pipeline is not held.
// The pipeline depth is set by the square-root pipeline (31 stages) and the
// four divider lanes (COMPONENT_WIDTH - 1 stages). The whole pipeline holds
// only when the output register is full and stalled with a result behind it.
// Synchronous active-high reset empties the pipeline; payload is not reset.
`default_nettype none
module quaternion_nlerp import qnl_pkg::*; #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int FRACTION_WIDTH  = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_a_w,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_a_x,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_a_y,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_a_z,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_b_w,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_b_x,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_b_y,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_b_z,
   input  wire logic        [FRACTION_WIDTH:0]    req_blend,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed      [COMPONENT_WIDTH-1:0] rsp_r_w,
   output logic signed      [COMPONENT_WIDTH-1:0] rsp_r_x,
   output logic signed      [COMPONENT_WIDTH-1:0] rsp_r_y,
   output logic signed      [COMPONENT_WIDTH-1:0] rsp_r_z,
   output logic                                   rsp_degenerate
);

   localparam int CW    = COMPONENT_WIDTH;
   localparam int FW    = FRACTION_WIDTH;
   localparam int PW    = 2 * CW;
   localparam int DW    = 2 * CW + 2;
   localparam int MW    = CW + FW + 2;
   localparam int LW    = $clog2(MW + 1);
   localparam int NW    = UNORM_BITS + CW - 1;
   localparam int QW    = CW - 1;
   localparam int DEPTH = ROOT_WIDTH + CW + 8;

   logic en, out_load;
   logic [DEPTH-1:0] vld_ff;

   // Stage 1: saturate the fraction, products for the dot product.
   logic signed [CW-1:0] a_in [LANES];
   logic signed [CW-1:0] b_in [LANES];
   logic signed [CW-1:0] a1_ff [LANES];
   logic signed [CW-1:0] b1_ff [LANES];
   logic signed [PW-1:0] ab_ff [LANES];
   logic        [FW:0]   t_in, t1_ff, tc1_ff;

   assign a_in[0] = req_a_w;
   assign a_in[1] = req_a_x;
   assign a_in[2] = req_a_y;
   assign a_in[3] = req_a_z;
   assign b_in[0] = req_b_w;
   assign b_in[1] = req_b_x;
   assign b_in[2] = req_b_y;
   assign b_in[3] = req_b_z;

   assign t_in = req_blend[FW] ? ((FW+1)'(1) << FW) : req_blend;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LANES; i++) begin
            a1_ff[i] <= a_in[i];
            b1_ff[i] <= b_in[i];
            ab_ff[i] <= a_in[i] * b_in[i];
         end
         t1_ff  <= t_in;
         tc1_ff <= ((FW+1)'(1) << FW) - t_in;
      end
   end

   // Stage 2: sign of the dot product picks the nearer form of b.
   logic signed [DW-1:0] dot_sum;
   logic signed [CW-1:0] a2_ff [LANES];
   logic signed [CW:0]   b2_ff [LANES];
   logic        [FW:0]   t2_ff, tc2_ff;

   always_comb begin
      dot_sum = '0;
      for (int i = 0; i < LANES; i++) begin
         dot_sum = dot_sum + DW'(ab_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LANES; i++) begin
            a2_ff[i] <= a1_ff[i];
            b2_ff[i] <= dot_sum[DW-1] ? -(CW+1)'(b1_ff[i]) : (CW+1)'(b1_ff[i]);
         end
         t2_ff  <= t1_ff;
         tc2_ff <= tc1_ff;
      end
   end

   // Stages 3 and 4: blend lanes.
   logic [MW-1:0] mag4 [LANES];
   logic [LANES-1:0] neg4;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      qnl_lane #(.CW(CW), .FW(FW)) u_lane (
         .clock (clock),
         .en    (en),
         .a     (a2_ff[i]),
         .b     (b2_ff[i]),
         .t     (t2_ff),
         .tc    (tc2_ff),
         .mag   (mag4[i]),
         .neg   (neg4[i])
      );
   end

   // Stage 5: the bit length of the largest magnitude equals that of the OR.
   logic [MW-1:0]    mag_or;
   logic [LW-1:0]    len_in, len5_ff;
   logic [MW-1:0]    mag5_ff [LANES];
   logic [LANES-1:0] neg5_ff;
   logic             nz5_ff;

   always_comb begin
      mag_or = '0;
      for (int i = 0; i < LANES; i++) begin
         mag_or = mag_or | mag4[i];
      end
      len_in = '0;
      for (int j = 0; j < MW; j++) begin
         if (mag_or[j]) begin
            len_in = LW'(j + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LANES; i++) begin
            mag5_ff[i] <= mag4[i];
         end
         neg5_ff <= neg4;
         nz5_ff  <= |mag_or;
         len5_ff <= len_in;
      end
   end

   // Stages 6 to 8: normalize, square, sum.
   logic [UNORM_BITS-1:0]   u6_ff  [LANES];
   logic [2*UNORM_BITS-1:0] sq7_ff [LANES];
   logic [SQ_WIDTH-1:0]     sq_sum, s8_ff;

   always_comb begin
      sq_sum = '0;
      for (int i = 0; i < LANES; i++) begin
         sq_sum = sq_sum + SQ_WIDTH'(sq7_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LANES; i++) begin
            u6_ff[i]  <= UNORM_BITS'({mag5_ff[i], {UNORM_BITS{1'b0}}} >> len5_ff);
            sq7_ff[i] <= u6_ff[i] * u6_ff[i];
         end
         s8_ff <= sq_sum;
      end
   end

   logic [ROOT_WIDTH-1:0] root;

   qnl_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .s     (s8_ff),
      .root  (root)
   );

   // Normalized magnitudes wait for the root.
   logic [LANES*UNORM_BITS-1:0] u_pack, u_late;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         u_pack[i*UNORM_BITS +: UNORM_BITS] = u6_ff[i];
      end
   end

   qnl_delay #(.WIDTH(LANES * UNORM_BITS), .DEPTH(ROOT_WIDTH + 2)) u_udly (
      .clock (clock),
      .en    (en),
      .din   (u_pack),
      .dout  (u_late)
   );

   // Dividend with half the divisor added for rounding.
   logic [NW-1:0]         num_ff [LANES];
   logic [ROOT_WIDTH-1:0] den_ff;
   logic [QW-1:0]         quo [LANES];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LANES; i++) begin
            num_ff[i] <= (NW'(u_late[i*UNORM_BITS +: UNORM_BITS]) << (CW - 2))
                       + NW'(root >> 1);
         end
         den_ff <= root;
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_div
      qnl_div #(.CW(CW)) u_div (
         .clock (clock),
         .en    (en),
         .num   (num_ff[i]),
         .den   (den_ff),
         .quo   (quo[i])
      );
   end

   // Signs and the nonzero flag ride alongside to the output.
   logic [LANES:0] side_late;

   qnl_delay #(.WIDTH(LANES + 1), .DEPTH(DEPTH - 5)) u_sdly (
      .clock (clock),
      .en    (en),
      .din   ({nz5_ff, neg5_ff}),
      .dout  (side_late)
   );

   logic signed [CW-1:0] r_in [LANES];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         r_in[i] = side_late[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
         if (!side_late[LANES]) begin
            r_in[i] = (i == 0) ? (CW'(1) <<< (CW - 2)) : '0;
         end
      end
   end

   // The pipeline moves unless a finished result is blocked behind a stalled output.
   logic rsp_valid_ff;
   logic signed [CW-1:0] r_ff [LANES];
   logic degenerate_ff;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign en        = !(vld_ff[DEPTH-1] && rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
         end
         if (out_load) begin
            rsp_valid_ff <= vld_ff[DEPTH-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         for (int i = 0; i < LANES; i++) begin
            r_ff[i] <= r_in[i];
         end
         degenerate_ff <= !side_late[LANES];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_r_w        = r_ff[0];
   assign rsp_r_x        = r_ff[1];
   assign rsp_r_y        = r_ff[2];
   assign rsp_r_z        = r_ff[3];
   assign rsp_degenerate = degenerate_ff;

   localparam logic signed [CW:0] UnitPos = (CW+1)'(1) <<< (CW - 2);

   a_degen_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_r_x == 0 && rsp_r_y == 0 && rsp_r_z == 0
                                      && rsp_r_w == CW'(UnitPos))
      else $error("degenerate result is not the identity");

   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         (CW+1)'(rsp_r_w) <= UnitPos && (CW+1)'(rsp_r_w) >= -UnitPos)
      else $error("normalized real part exceeds one");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output is free");

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(vld_ff))
      else $error("pipeline moved while held");

endmodule
`default_nettype wire

// ===== rtl/core/qnl_delay.sv =====
// Enabled shift-register delay line used to carry side data past the long
// arithmetic stages. No package dependency.
`default_nettype none
module qnl_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int k = 1; k < DEPTH; k++) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule
`default_nettype wire

// ===== rtl/core/qnl_lane.sv =====
// One component lane of the blend: weights both inputs, sums them and splits
// the result into magnitude and sign over two register stages. Uses qnl_pkg.
`default_nettype none
module qnl_lane import qnl_pkg::*; #(
   parameter int CW = 16,
   parameter int FW = 16
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic signed [CW-1:0]  a,
   input  wire logic signed [CW:0]    b,
   input  wire logic        [FW:0]    t,
   input  wire logic        [FW:0]    tc,
   output logic             [CW+FW+1:0] mag,
   output logic                       neg
);

   localparam int MW = CW + FW + 2;

   logic signed [MW:0]   pa_in, pa_ff, pb_in, pb_ff, v_sum;
   logic        [MW-1:0] mag_in, mag_ff;
   logic                 neg_in, neg_ff;

   assign pa_in = a * $signed({1'b0, tc});
   assign pb_in = b * $signed({1'b0, t});

   assign v_sum  = pa_ff + pb_ff;
   assign neg_in = v_sum[MW];
   assign mag_in = neg_in ? MW'(-v_sum) : MW'(v_sum);

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   assign mag = mag_ff;
   assign neg = neg_ff;

endmodule
`default_nettype wire

// ===== rtl/core/qnl_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, for the sum of
// squared normalized magnitudes. Uses qnl_pkg.
`default_nettype none
module qnl_isqrt import qnl_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [SQ_WIDTH-1:0]   s,
   output logic      [ROOT_WIDTH-1:0] root
);

   logic [SQ_WIDTH-1:0]   rem_ff  [ROOT_WIDTH-1];
   logic [ROOT_WIDTH-1:0] root_ff [ROOT_WIDTH];

   for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_stage
      localparam int BitPos = ROOT_WIDTH - 1 - k;
      logic [SQ_WIDTH-1:0]   rem_prev, trial;
      logic [ROOT_WIDTH-1:0] root_prev;
      logic                  take;

      if (k == 0) begin : g_first
         assign rem_prev  = s;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // The found upper root bits and the trial bit do not overlap.
      assign trial = (SQ_WIDTH'(root_prev) << (BitPos + 1))
                   | (SQ_WIDTH'(1) << (2 * BitPos));
      assign take  = rem_prev >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[k] <= take ? (root_prev | (ROOT_WIDTH'(1) << BitPos)) : root_prev;
         end
      end

      if (k < ROOT_WIDTH - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= take ? (rem_prev - trial) : rem_prev;
            end
         end
      end
   end

   assign root = root_ff[ROOT_WIDTH-1];

endmodule
`default_nettype wire

// ===== rtl/core/qnl_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, that scales one
// normalized magnitude by the root of the sum of squares. Uses qnl_pkg.
`default_nettype none
module qnl_div import qnl_pkg::*; #(
   parameter int CW = 16
) (
   input  wire logic                            clock,
   input  wire logic                            en,
   input  wire logic [UNORM_BITS+CW-2:0]        num,
   input  wire logic [ROOT_WIDTH-1:0]           den,
   output logic      [CW-2:0]                   quo
);

   localparam int NW = UNORM_BITS + CW - 1;
   localparam int QW = CW - 1;

   logic [NW-1:0]         rem_ff [QW-1];
   logic [ROOT_WIDTH-1:0] den_ff [QW-1];
   logic [QW-1:0]         quo_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int BitPos = QW - 1 - k;
      logic [NW-1:0]         rem_prev, trial;
      logic [ROOT_WIDTH-1:0] den_prev;
      logic [QW-1:0]         quo_prev;
      logic                  take;

      if (k == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      assign trial = NW'(den_prev) << BitPos;
      assign take  = rem_prev >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[k] <= take ? (quo_prev | (QW'(1) << BitPos)) : quo_prev;
         end
      end

      if (k < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= take ? (rem_prev - trial) : rem_prev;
               den_ff[k] <= den_prev;
            end
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for quaternion_nlerp: directed table, then random
// transactions checked against an in-bench normalized-lerp predictor.
// Depends on rtl/core/qnl_pkg.sv and rtl/core/quaternion_nlerp.sv.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import qnl_pkg::*;

   localparam int CW = 16;
   localparam int FW = 16;
   localparam int CFRAC = CW - 2;
   localparam logic [FW:0] ONE_T = (FW+1)'(1) << FW;
   localparam int STALL_LIMIT = 20000;
   localparam int N_RANDOM = 1530;

   typedef struct packed {
      logic signed [CW-1:0] a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z;
      logic [FW:0]          blend;
   } quat_req_type;

   typedef struct packed {
      logic signed [CW-1:0] r_w, r_x, r_y, r_z;
      logic                 degenerate;
   } quat_rsp_type;

   typedef struct packed {
      quat_req_type req;
      logic         fixed;
      quat_rsp_type rsp;
   } table_row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0;
   quat_req_type drive = '0;
   logic req_stall, rsp_valid;
   logic signed [CW-1:0] rsp_r_w, rsp_r_x, rsp_r_y, rsp_r_z;
   logic rsp_degenerate;

   quaternion_nlerp #(.COMPONENT_WIDTH(CW), .FRACTION_WIDTH(FW)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_w(drive.a_w), .req_a_x(drive.a_x), .req_a_y(drive.a_y),
      .req_a_z(drive.a_z), .req_b_w(drive.b_w), .req_b_x(drive.b_x),
      .req_b_y(drive.b_y), .req_b_z(drive.b_z), .req_blend(drive.blend),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_r_w(rsp_r_w), .rsp_r_x(rsp_r_x), .rsp_r_y(rsp_r_y),
      .rsp_r_z(rsp_r_z), .rsp_degenerate(rsp_degenerate));

   initial begin
      forever #2 clock = ~clock;
   end

   quat_rsp_type pending_rsp[$];
   int errors = 0;
   int idle_cycles = 0;
   bit stim_done = 0;
   bit hold_off = 0;

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic quat_rsp_type nlerp_predict(quat_req_type q);
      longint av[4], bv[4], blended[4];
      longint unsigned mag[4], un[4], peak, sumsq, root, tt, tc, quo;
      longint dot;
      int len;
      quat_rsp_type res;
      logic signed [CW-1:0] comp[4];
      av = '{q.a_w, q.a_x, q.a_y, q.a_z};
      bv = '{q.b_w, q.b_x, q.b_y, q.b_z};
      tt = (q.blend > ONE_T) ? ONE_T : q.blend;
      tc = ONE_T - tt;
      // Products of 16-bit values fit comfortably in 64 bits.
      dot = 0;
      for (int i = 0; i < 4; i++) dot += av[i] * bv[i];
      if (dot < 0) for (int i = 0; i < 4; i++) bv[i] = -bv[i];
      peak = 0;
      for (int i = 0; i < 4; i++) begin
         blended[i] = av[i] * longint'(tc) + bv[i] * longint'(tt);
         mag[i] = (blended[i] < 0) ? -blended[i] : blended[i];
         if (mag[i] > peak) peak = mag[i];
      end
      if (peak == 0) begin
         res.r_w = CW'(1) << CFRAC;
         res.r_x = 0; res.r_y = 0; res.r_z = 0;
         res.degenerate = 1;
         return res;
      end
      len = 0;
      while ((peak >> len) != 0) len++;
      sumsq = 0;
      for (int i = 0; i < 4; i++) begin
         un[i] = (len > UNORM_BITS) ? mag[i] >> (len - UNORM_BITS)
                                    : mag[i] << (UNORM_BITS - len);
         sumsq += un[i] * un[i];
      end
      root = floor_sqrt(sumsq);
      for (int i = 0; i < 4; i++) begin
         quo = ((un[i] << CFRAC) + (root >> 1)) / root;
         if (blended[i] < 0) quo = -quo;
         comp[i] = quo[CW-1:0];
      end
      res.r_w = comp[0]; res.r_x = comp[1]; res.r_y = comp[2]; res.r_z = comp[3];
      res.degenerate = 0;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   function automatic int gap_length();
      int p;
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   function automatic logic [CW-1:0] rand_comp();
      int p;
      p = $urandom_range(9);
      if (p == 0) return 16'h8000;
      if (p == 1) return 16'h7fff;
      if (p == 2) return 0;
      if (p < 6) return 16'(int'($urandom_range(32767)) - 16384) >>> 1;
      return CW'($urandom);
   endfunction

   function automatic quat_req_type rand_req();
      quat_req_type q;
      int p;
      q.a_w = rand_comp(); q.a_x = rand_comp(); q.a_y = rand_comp(); q.a_z = rand_comp();
      p = $urandom_range(9);
      if (p == 0) begin
         // Opposite quaternions; the negative dot flips b, so they do not cancel.
         q.b_w = -q.a_w; q.b_x = -q.a_x; q.b_y = -q.a_y; q.b_z = -q.a_z;
      end else if (p == 1) begin
         q.b_w = q.a_w; q.b_x = q.a_x; q.b_y = q.a_y; q.b_z = q.a_z;
      end else begin
         q.b_w = rand_comp(); q.b_x = rand_comp(); q.b_y = rand_comp(); q.b_z = rand_comp();
      end
      p = $urandom_range(9);
      if (p == 0) q.blend = 0;
      else if (p == 1) q.blend = ONE_T;
      else if (p == 2) q.blend = (FW+1)'($urandom);
      else if (p == 3) q.blend = ONE_T >> 1;
      else q.blend = (FW+1)'($urandom_range(65536));
      return q;
   endfunction

   function automatic quat_req_type mk(int aw, ax, ay, az, bw, bx, by, bz, int t);
      quat_req_type q;
      q.a_w = CW'(aw); q.a_x = CW'(ax); q.a_y = CW'(ay); q.a_z = CW'(az);
      q.b_w = CW'(bw); q.b_x = CW'(bx); q.b_y = CW'(by); q.b_z = CW'(bz);
      q.blend = (FW+1)'(t);
      return q;
   endfunction

   function automatic table_row_type row(quat_req_type q, bit fixed, quat_rsp_type r);
      table_row_type tr;
      tr.req = q; tr.fixed = fixed; tr.rsp = r;
      return tr;
   endfunction

   localparam int Q1 = 1 << CFRAC;
   table_row_type directed[$];
   quat_rsp_type identity_rsp, none_rsp;

   // Called at a falling edge; returns at the falling edge after acceptance with
   // the valid still raised, so the next call decides whether a gap follows.
   task automatic send(quat_req_type q, quat_rsp_type want, bit no_gap);
      int gap;
      gap = no_gap ? 0 : gap_length();
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      drive <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(want);
      @(negedge clock);
   endtask

   // Sender.
   initial begin
      quat_req_type q;
      identity_rsp = '{r_w: CW'(Q1), r_x: 0, r_y: 0, r_z: 0, degenerate: 1};
      none_rsp = '0;
      directed.push_back(row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, identity_rsp));
      directed.push_back(row(mk(Q1, 0, 0, 0, -Q1, 0, 0, 0, 32768), 0, none_rsp));
      directed.push_back(row(mk(Q1, 0, 0, 0, 0, Q1, 0, 0, 32768), 0, none_rsp));
      directed.push_back(row(mk(Q1, 0, 0, 0, 0, Q1, 0, 0, 0), 1,
                             '{r_w: CW'(Q1), r_x: 0, r_y: 0, r_z: 0, degenerate: 0}));
      directed.push_back(row(mk(Q1, 0, 0, 0, 0, Q1, 0, 0, 65536), 1,
                             '{r_w: 0, r_x: CW'(Q1), r_y: 0, r_z: 0, degenerate: 0}));
      directed.push_back(row(mk(Q1, 0, 0, 0, 0, 0, Q1, 0, 131071), 1,
                             '{r_w: 0, r_x: 0, r_y: CW'(Q1), r_z: 0, degenerate: 0}));
      directed.push_back(row(mk(Q1, 0, 0, 0, 0, 0, 0, Q1, 65537), 0, none_rsp));
      directed.push_back(row(mk(-32768, -32768, -32768, -32768,
                                32767, 32767, 32767, 32767, 1), 0, none_rsp));
      directed.push_back(row(mk(32767, -32768, 32767, -32768,
                                32767, -32768, 32767, -32768, 65535), 0, none_rsp));
      // The negative dot flips b, so the two inputs reinforce instead of cancel.
      directed.push_back(row(mk(0, 0, 0, 1, 0, 0, 0, -1, 32768), 1,
                             '{r_w: 0, r_x: 0, r_y: 0, r_z: CW'(Q1), degenerate: 0}));
      directed.push_back(row(mk(1, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_rsp));
      directed.push_back(row(mk(1, 1, 1, 1, 1, 1, 1, 1, 12345), 0, none_rsp));
      directed.push_back(row(mk(Q1, 0, 0, 0, 0, 0, Q1, 0, 16384), 0, none_rsp));
      directed.push_back(row(mk(-Q1, 0, 0, 0, Q1, 0, 0, 0, 65536), 0, none_rsp));
      directed.push_back(row(mk(0, 0, 0, 0, 0, 0, 0, 0, 131071), 1, identity_rsp));
      directed.push_back(row(mk(32767, 32767, 32767, 32767,
                                -32768, -32768, -32768, -32768, 40000), 0, none_rsp));
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      foreach (directed[i]) begin
         send(directed[i].req, directed[i].fixed ? directed[i].rsp
                                                 : nlerp_predict(directed[i].req), 0);
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         q = rand_req();
         if (i == 400) hold_off = 1;
         // Back-to-back offers while the receiver holds off.
         send(q, nlerp_predict(q), i > 400 && i < 520);
      end
      req_valid <= 0;
      stim_done = 1;
   end

   // Receiver stall pattern.
   initial begin
      int gap;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            hold_off = 0;
            rsp_stall <= 1;
            repeat (300) @(negedge clock);
            rsp_stall <= 0;
         end else if ($urandom_range(3) == 0) begin
            gap = gap_length();
            if (gap != 0) begin
               rsp_stall <= 1;
               repeat (gap) @(negedge clock);
               rsp_stall <= 0;
            end
         end
      end
   end

   // Checker and watchdog.
   always @(posedge clock) begin
      quat_rsp_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_r_w !== want.r_w) report_mismatch("r_w", rsp_r_w, want.r_w);
               if (rsp_r_x !== want.r_x) report_mismatch("r_x", rsp_r_x, want.r_x);
               if (rsp_r_y !== want.r_y) report_mismatch("r_y", rsp_r_y, want.r_y);
               if (rsp_r_z !== want.r_z) report_mismatch("r_z", rsp_r_z, want.r_z);
               if (rsp_degenerate !== want.degenerate)
                  report_mismatch("degenerate", rsp_degenerate, want.degenerate);
            end
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL quaternion_nlerp");
            $finish;
         end
      end
   end

   // End of run.
   initial begin
      wait (stim_done);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (CW + 60) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("PASS quaternion_nlerp");
      end else begin
         $display("FAIL quaternion_nlerp");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/qnl_pkg.sv
rtl/core/qnl_delay.sv
rtl/core/qnl_lane.sv
rtl/core/qnl_isqrt.sv
rtl/core/qnl_div.sv
rtl/core/quaternion_nlerp.sv
tb/testbench.sv
